### rtl/core/ita_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
// No dependencies; every other file of the block but ita_if imports this package.
`timescale 1ns / 1ps

package ita_pkg;

   localparam int MAG_W       = 64;
   localparam int DEC_DIGITS  = 20;
   localparam int HEX_DIGITS  = 16;
   localparam int DIG_W       = DEC_DIGITS * 4;
   localparam int CNT_W       = 5;
   localparam int BIT_CNT_W   = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_X     = 8'h78;  // 'x'

   // Classified number on its way from the front end to the converter.
   typedef struct packed {
      logic             hex;
      logic             neg;
      logic             zero;
      logic [MAG_W-1:0] mag;
   } ita_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_ALIGN,
      ST_SIGN,
      ST_HEX0,
      ST_HEXX,
      ST_DIGIT
   } ita_state_type;

   // One digit (0..15) to its uppercase ASCII character.
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'b0, d};
      end else begin
         c = CHAR_UPPER + {4'b0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

### rtl/core/ita_if.sv
// Handshake channels of the formatter: number words in, character words out.
// Depends on nothing.
`timescale 1ns / 1ps

interface ita_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ita_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last;

   modport source (output valid, output text_byte, output last, input ready);
   modport sink   (input valid, input text_byte, input last, output ready);
endinterface

### rtl/core/ita_front.sv
// Front end: takes number words and classifies them (mode, sign, zero, magnitude).
// Depends on ita_pkg and ita_req_if.
`timescale 1ns / 1ps

module ita_front
   import ita_pkg::*;
(
   ita_req_if.sink          req_port,
   output logic             item_valid,
   input  logic             item_ready,
   output ita_item_type     item
);

   logic neg;

   // Two's complement only in decimal mode; negating the most negative
   // value wraps to 2^63, which is its true unsigned magnitude.
   assign neg            = ~req_port.kind & req_port.value[MAG_W-1];
   assign item.hex       = req_port.kind;
   assign item.neg       = neg;
   assign item.zero      = (req_port.value == '0);
   assign item.mag       = neg ? (~req_port.value + {{(MAG_W-1){1'b0}}, 1'b1})
                               : req_port.value;
   assign item_valid     = req_port.valid;
   assign req_port.ready = item_ready;

endmodule

### rtl/core/ita_queue.sv
// Two-entry queue between the front end and the converter.
// Depends on ita_pkg.
`timescale 1ns / 1ps

module ita_queue
   import ita_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  ita_item_type push_item,
   output logic         head_valid,
   input  logic         pop,
   output ita_item_type head_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   ita_item_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = (count_ff != QUEUE_DEPTH[$clog2(QUEUE_DEPTH+1)-1:0]);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/ita_back.sv
// Back end: binary to BCD by shift-and-add-3, leading zero strip, and the
// character sequencer with its output register. Depends on ita_pkg, ita_rsp_if.
`timescale 1ns / 1ps

module ita_back
   import ita_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  ita_item_type head_item,
   output logic         pop,
   ita_rsp_if.source    rsp_port
);

   ita_state_type        state_ff, state_in;
   logic                 hex_ff, hex_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [DIG_W-1:0]     dig_ff, dig_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;

   logic             out_free;
   logic             emit;
   logic [7:0]       emit_byte;
   logic             emit_last;
   logic [DIG_W-1:0] dig_adj;
   logic [3:0]       top_digit;
   logic             align_done;

   assign out_free   = ~out_valid_ff | rsp_port.ready;
   assign top_digit  = dig_ff[DIG_W-1 -: 4];
   assign align_done = (top_digit != 4'd0) || (cnt_ff == CNT_W'(1));

   // add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         dig_adj[i*4 +: 4] = (dig_ff[i*4 +: 4] >= 4'd5) ? dig_ff[i*4 +: 4] + 4'd3
                                                        : dig_ff[i*4 +: 4];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               state_in = head_item.hex ? ST_ALIGN : ST_CONV;
            end
         end
         ST_CONV: begin
            if (bit_cnt_ff == BIT_CNT_W'(MAG_W - 1)) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (align_done) begin
               if (neg_ff) begin
                  state_in = ST_SIGN;
               end else if (hex_ff && !zero_ff) begin
                  state_in = ST_HEX0;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_DIGIT;
         end
         ST_HEX0: begin
            if (out_free) state_in = ST_HEXX;
         end
         ST_HEXX: begin
            if (out_free) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (out_free && cnt_ff == CNT_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop        = 1'b0;
      emit       = 1'b0;
      emit_byte  = CHAR_ZERO;
      emit_last  = 1'b0;
      hex_in     = hex_ff;
      neg_in     = neg_ff;
      zero_in    = zero_ff;
      mag_in     = mag_ff;
      dig_in     = dig_ff;
      cnt_in     = cnt_ff;
      bit_cnt_in = bit_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop        = 1'b1;
               hex_in     = head_item.hex;
               neg_in     = head_item.neg;
               zero_in    = head_item.zero;
               mag_in     = head_item.mag;
               bit_cnt_in = '0;
               if (head_item.hex) begin
                  dig_in = {head_item.mag, {(DIG_W-MAG_W){1'b0}}};
                  cnt_in = CNT_W'(HEX_DIGITS);
               end else begin
                  dig_in = '0;
                  cnt_in = CNT_W'(DEC_DIGITS);
               end
            end
         end
         ST_CONV: begin
            dig_in     = {dig_adj[DIG_W-2:0], mag_ff[MAG_W-1]};
            mag_in     = {mag_ff[MAG_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
         end
         ST_ALIGN: begin
            if (!align_done) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SIGN: begin
            emit      = out_free;
            emit_byte = CHAR_MINUS;
         end
         ST_HEX0: begin
            emit      = out_free;
            emit_byte = CHAR_ZERO;
         end
         ST_HEXX: begin
            emit      = out_free;
            emit_byte = CHAR_X;
         end
         ST_DIGIT: begin
            emit      = out_free;
            emit_byte = digit_char(top_digit);
            emit_last = (cnt_ff == CNT_W'(1));
            if (out_free) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // output register: holds a word until the sink takes it
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hex_ff      <= hex_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      mag_ff      <= mag_in;
      dig_ff      <= dig_in;
      cnt_ff      <= cnt_in;
      bit_cnt_ff  <= bit_cnt_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_port.valid     = out_valid_ff;
   assign rsp_port.text_byte = out_byte_ff;
   assign rsp_port.last      = out_last_ff;

endmodule

### rtl/core/integer_to_ascii_formatter.sv
// Integer to ASCII formatter. Each request word carries a 64-bit value and a
// mode bit (kind: 0 = signed decimal, 1 = hex). The block answers with the
// value's text, one ASCII character per response word, most significant
// character first, with last set on the final character. Decimal mode reads
// the value as two's complement and prefixes '-' for negatives (the most
// negative value prints as -9223372036854775808); hex mode prints "0x" and
// uppercase digits without leading zeros. Zero prints as a single '0' in both
// modes. Structure: a front end classifies the word and drops it into a
// two-entry queue, so up to two numbers can be accepted ahead of the one
// being printed. The converter handles one number at a time: a decimal number
// is loaded, runs a shift-and-add-3 pass over its magnitude bits, has its
// leading zero digits stripped and is then sent one character per response
// word, after a minus sign if negative. A hex number skips the BCD pass: it is
// loaded, its leading zero digits are stripped, the 0x prefix is sent and then
// its digits (zero has no prefix). Response backpressure only stretches the
// character phase: a character is staged whenever the output register is
// empty or its word is taken that cycle.
// Depends on ita_pkg, ita_if, ita_front, ita_queue and ita_back.
`timescale 1ns / 1ps

module integer_to_ascii_formatter
   import ita_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ita_req_if.sink    req_port,
   ita_rsp_if.source  rsp_port
);

   ita_item_type front_item;
   ita_item_type head_item;
   logic         front_valid;
   logic         front_ready;
   logic         head_valid;
   logic         pop;

   // classify: mode, sign, zero, magnitude
   ita_front u_front (
      .req_port   (req_port),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   // decouples acceptance from the long conversion
   ita_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .head_valid (head_valid),
      .pop        (pop),
      .head_item  (head_item)
   );

   // BCD conversion and character sequencing
   ita_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_port   (rsp_port)
   );

endmodule

### test/integer_to_ascii_formatter_tb.sv
// Self-checking testbench for integer_to_ascii_formatter: directed and random
// numbers in both modes, every character word checked against typed text or a predictor.
// Depends on ita_pkg, ita_if and the formatter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
   import ita_pkg::*;

   localparam logic KIND_DEC = 1'b0;
   localparam logic KIND_HEX = 1'b1;

   localparam int RANDOM_WORDS  = 460;   // split evenly over the idle phases
   localparam int NUM_PHASES    = 4;
   localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
   localparam int SETTLE_CYCLES = 150;   // > one decimal conversion

   localparam logic [8*16-1:0] HEX_CHARS = "0123456789ABCDEF";

   // One character word as the block should deliver it.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last;
   } char_word_type;

   // Directed row; an empty text means "ask the predictor".
   typedef struct {
      logic        kind;
      logic [63:0] value;
      string       text;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ita_req_if req_ch ();
   ita_rsp_if rsp_ch ();

   integer_to_ascii_formatter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   always #1 clock = ~clock;

   char_word_type expected_chars[$];
   int            errors      = 0;
   int            send_idle   = 0;   // percent of cycles the sender holds off
   int            rsp_stall   = 0;   // percent of cycles the receiver stalls
   int            quiet_count = 0;

   // Corners: zero in both modes, unit values, the signed extremes (the most
   // negative value must print its true magnitude), all ones in hex, digit
   // rollovers. Rows with typed text are checked against that text directly.
   directed_row_type directed_rows[] = '{
      '{KIND_DEC, 64'd0,                   "0"},
      '{KIND_HEX, 64'd0,                   "0"},
      '{KIND_DEC, 64'd1,                   "1"},
      '{KIND_HEX, 64'd1,                   "0x1"},
      '{KIND_DEC, 64'hFFFF_FFFF_FFFF_FFFF, "-1"},
      '{KIND_DEC, 64'h8000_0000_0000_0000, "-9223372036854775808"},
      '{KIND_DEC, 64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807"},
      '{KIND_HEX, 64'hFFFF_FFFF_FFFF_FFFF, "0xFFFFFFFFFFFFFFFF"},
      '{KIND_HEX, 64'h8000_0000_0000_0000, "0x8000000000000000"},
      '{KIND_DEC, 64'd9,                   "9"},
      '{KIND_DEC, 64'd10,                  "10"},
      '{KIND_HEX, 64'hA,                   "0xA"},
      '{KIND_HEX, 64'h10,                  "0x10"},
      '{KIND_HEX, 64'h0123_4567_89AB_CDEF, "0x123456789ABCDEF"},
      '{KIND_DEC, 64'd12345,               "12345"},
      '{KIND_DEC, 64'd1000000000000000000, ""},
      '{KIND_DEC, -64'sd10,                ""},
      '{KIND_HEX, 64'hFEDC_BA98_7654_3210, ""},
      '{KIND_DEC, 64'h8000_0000_0000_0001, ""},
      '{KIND_DEC, 64'hAAAA_AAAA_AAAA_AAAA, ""},
      '{KIND_HEX, 64'h5555_5555_5555_5555, ""},
      '{KIND_DEC, 64'h0000_0000_FFFF_FFFF, ""}
   };

   // Queue one number's characters, last flag on the final one.
   function automatic void queue_text(input logic [7:0] text[$]);
      for (int i = 0; i < text.size(); i++) begin
         expected_chars.push_back('{text_byte: text[i], last: (i == text.size() - 1)});
      end
   endfunction

   // Formats one number the way the block should and queues its characters.
   function automatic void predict_text(input logic kind, input logic [63:0] value);
      logic [63:0] mag;
      logic [7:0]  rev[$];
      logic [7:0]  text[$];
      if (value == 64'd0) begin
         text.push_back(CHAR_ZERO);             // no 0x prefix for zero
      end else if (kind == KIND_DEC) begin
         mag = value[63] ? (~value + 64'd1) : value;   // most negative maps to 2**63
         while (mag != 64'd0) begin
            rev.push_back(CHAR_ZERO + 8'(mag % 64'd10));
            mag = mag / 64'd10;
         end
         if (value[63]) begin
            text.push_back(CHAR_MINUS);
         end
      end else begin
         mag = value;
         while (mag != 64'd0) begin
            rev.push_back(HEX_CHARS[8 * (15 - int'(mag[3:0])) +: 8]);
            mag = mag >> 4;
         end
         text.push_back(CHAR_ZERO);
         text.push_back(CHAR_X);
      end
      while (rev.size() != 0) begin
         text.push_back(rev.pop_back());
      end
      queue_text(text);
   endfunction

   // Random value biased toward short texts, digit-count boundaries and extremes.
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      logic [63:0] p;
      int          k;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: v = 64'd0;
               1: v = 64'h8000_0000_0000_0000;
               2: v = 64'hFFFF_FFFF_FFFF_FFFF;
               default: v = 64'h7FFF_FFFF_FFFF_FFFF;
            endcase
         end
         1, 2: v = v >> $urandom_range(63);
         3: v = ~(v >> $urandom_range(63)) + 64'd1;    // small negative
         4: begin
            k = $urandom_range(19);
            p = 64'd1;
            repeat (k) p = p * 64'd10;
            v = p + 64'($urandom_range(2)) - 64'd1;
         end
         5: begin
            k = $urandom_range(15);
            v = (64'd1 << (4 * k)) + 64'($urandom_range(2)) - 64'd1;
         end
         default: ;
      endcase
      return v;
   endfunction

   // Present one number word and hold it until the block takes it.
   task automatic send_number(input logic kind, input logic [63:0] value, input string text);
      logic [7:0] typed[$];
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (text.len() != 0) begin
         for (int i = 0; i < text.len(); i++) typed.push_back(text[i]);
         queue_text(typed);
      end else begin
         predict_text(kind, value);
      end
   endtask

   // Sender quiet until every queued character has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // Receiver backpressure.
   always @(posedge clock) begin
      rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall);
   end

   // Character checker: every accepted word against the oldest expectation.
   always @(posedge clock) begin
      char_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, got byte %h last %b",
                     $time, rsp_ch.text_byte, rsp_ch.last);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_ch.text_byte !== want.text_byte) begin
               errors++;
               $display("%0t: text_byte expected %h got %h",
                        $time, want.text_byte, rsp_ch.text_byte);
            end
            if (rsp_ch.last !== want.last) begin
               errors++;
               $display("%0t: last expected %b got %b", $time, want.last, rsp_ch.last);
            end
         end
      end
   end

   // Watchdog: too long without any handshake means the block is stuck.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
         if (quiet_count >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int idle_pct[NUM_PHASES];
      int stall_pct[NUM_PHASES];
      idle_pct  = '{0, 64, 0, 34};
      stall_pct = '{0, 0, 64, 34};
      req_ch.valid = 1'b0;
      req_ch.kind  = KIND_DEC;
      req_ch.value = 64'd0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed corners, no idling on either side
      foreach (directed_rows[i]) begin
         send_number(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].text);
      end
      wait_drained();

      // random numbers under each idle mix; a full drain separates the phases
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle = idle_pct[ph];
         rsp_stall = stall_pct[ph];
         repeat (RANDOM_WORDS / NUM_PHASES) begin
            send_number(1'($urandom_range(1)), pick_value(), "");
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
